// ===== rtl/handle_slot_table_with_dirty_range_macros.svh =====
// Assertion macros for the slot table block
`ifndef HANDLE_SLOT_TABLE_WITH_DIRTY_RANGE_MACROS_SVH
`define HANDLE_SLOT_TABLE_WITH_DIRTY_RANGE_MACROS_SVH
// implication checked each clock, masked during reset
`define HST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define HST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/hst_pkg.sv =====
// -----------------------------------------------------------------------------
// hst_pkg
// Shared types and codes for the slot table block.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package hst_pkg;
    localparam logic [2:0] OP_ALLOC     = 3'd0;
    localparam logic [2:0] OP_ALLOC_RNG = 3'd1;
    localparam logic [2:0] OP_RELEASE   = 3'd2;
    localparam logic [2:0] OP_REL_RNG   = 3'd3;
    localparam logic [2:0] OP_READ      = 3'd4;
    localparam logic [2:0] OP_WRITE     = 3'd5;
    localparam logic [2:0] OP_FLUSH     = 3'd6;
    localparam logic [2:0] OP_CLEAR     = 3'd7;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_STK  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request for the decide step
        logic rd;        // issue entry/stack read
        logic exec;      // apply a non-range op
        logic walk;      // one step of a range op
        logic finish;    // present result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_range;  // accepted range op
        logic need_rd;   // op needs a memory read before exec
        logic walk_last; // current walk step is the last
    } t_stat;
endpackage
`default_nettype wire

// ===== rtl/hst_ram.sv =====
// -----------------------------------------------------------------------------
// hst_ram
// Single-port-write, single-port-read RAM with registered read data.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module hst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/hst_ctrl.sv =====
// -----------------------------------------------------------------------------
// hst_ctrl
// Sequencer: idle, decide, read, execute, walk and done steps of each request.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module hst_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_start,
    input  wire hst_pkg::t_stat i_stat,
    output hst_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.is_range) begin
                    n_state = S_WALK;
                end else if (i_stat.need_rd) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_RD;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_RD: n_state = S_EXEC;
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_DONE;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
endmodule
`default_nettype wire

// ===== rtl/hst_dp.sv =====
// -----------------------------------------------------------------------------
// hst_dp
// Datapath: entry stores, free stack, counters and dirty span.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module hst_dp #(
    parameter int CAPACITY = 1024,
    parameter int ID_WIDTH = 32
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire hst_pkg::t_cmd i_cmd,
    output hst_pkg::t_stat o_stat,
    input  wire [2:0]      i_operation,
    input  wire [9:0]      i_slot,
    input  wire [10:0]     i_span_count,
    input  wire [3:0]      i_field_mask,
    input  wire [31:0]     i_transform_in,
    input  wire [31:0]     i_geometry_in,
    input  wire [31:0]     i_material_in,
    input  wire [31:0]     i_texture_in,
    output logic           o_done,
    output logic [1:0]     o_status,
    output logic [9:0]     o_result_slot,
    output logic [31:0]    o_transform_out,
    output logic [31:0]    o_geometry_out,
    output logic [31:0]    o_material_out,
    output logic [31:0]    o_texture_out,
    output logic           o_span_valid,
    output logic [9:0]     o_span_first,
    output logic [9:0]     o_span_last
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 11) ? CW + 1 : 12;
    localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

    // request capture
    logic [2:0]          r_op;
    logic [9:0]          r_slot;
    logic [10:0]         r_cnt;
    logic [3:0]          r_mask;
    logic [ID_WIDTH-1:0] r_v [4];

    // control state
    logic [CW-1:0] r_free, r_used;
    logic [AW-1:0] r_low, r_high;
    logic          r_mv;
    logic [1:0]    r_status;
    logic          r_go;      // decided request is granted
    logic [AW-1:0] r_h;       // target entry / walk pointer
    logic [10:0]   r_left;
    logic [AW-1:0] r_base;
    logic          r_go_cap;  // decide step marker: cycle after load

    // result registers
    logic          r_done;
    logic [9:0]    r_rslot;
    logic [31:0]   r_rd [4];
    logic          r_sv;
    logic [9:0]    r_sf, r_sl;

    // memories
    logic                we_e;
    logic [3:0]          we_f;
    logic [AW-1:0]       e_addr;
    logic [ID_WIDTH-1:0] e_wd [4];
    logic [ID_WIDTH-1:0] e_rd [4];
    logic                we_s;
    logic [AW-1:0]       s_waddr, s_raddr;
    logic [AW-1:0]       s_wd, s_rd;

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_st
            hst_ram #(.WIDTH(ID_WIDTH), .DEPTH(CAPACITY)) u_ram (
                .i_clk  (i_clk),
                .i_we   (we_f[g]),
                .i_waddr(e_addr),
                .i_wdata(e_wd[g]),
                .i_raddr(e_addr),
                .o_rdata(e_rd[g])
            );
        end
    endgenerate

    hst_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_stack (
        .i_clk  (i_clk),
        .i_we   (we_s),
        .i_waddr(s_waddr),
        .i_wdata(s_wd),
        .i_raddr(s_raddr),
        .o_rdata(s_rd)
    );

    // decision on captured request (wide compares)
    logic [XW-1:0] slot_x, cnt_x, used_x, free_x;
    logic          slot_bad, rr_bad, ar_full, rr_stk;
    assign slot_x   = XW'(r_slot);
    assign cnt_x    = XW'(r_cnt);
    assign used_x   = XW'(r_used);
    assign free_x   = XW'(r_free);
    assign slot_bad = (slot_x >= used_x);
    assign ar_full  = (used_x + cnt_x > CAP_X);
    assign rr_bad   = (r_cnt == '0) || (slot_x + cnt_x > used_x);
    assign rr_stk   = (free_x + cnt_x > CAP_X);

    logic [1:0] dec_status;
    logic       dec_go, dec_range;
    always_comb begin
        dec_status = hst_pkg::ST_OK;
        dec_go     = 1'b0;
        dec_range  = 1'b0;
        case (r_op)
            hst_pkg::OP_ALLOC: begin
                if (r_free == '0 && used_x >= CAP_X) begin
                    dec_status = hst_pkg::ST_FULL;
                end else begin
                    dec_go = 1'b1;
                end
            end
            hst_pkg::OP_ALLOC_RNG: begin
                if (r_cnt == '0) begin
                    dec_status = hst_pkg::ST_BAD;
                end else if (ar_full) begin
                    dec_status = hst_pkg::ST_FULL;
                end else begin
                    dec_go    = 1'b1;
                    dec_range = 1'b1;
                end
            end
            hst_pkg::OP_RELEASE: begin
                if (slot_bad) begin
                    dec_status = hst_pkg::ST_BAD;
                end else if (free_x >= CAP_X) begin
                    dec_status = hst_pkg::ST_STK;
                end else begin
                    dec_go = 1'b1;
                end
            end
            hst_pkg::OP_REL_RNG: begin
                if (rr_bad) begin
                    dec_status = hst_pkg::ST_BAD;
                end else if (rr_stk) begin
                    dec_status = hst_pkg::ST_STK;
                end else begin
                    dec_go    = 1'b1;
                    dec_range = 1'b1;
                end
            end
            hst_pkg::OP_READ, hst_pkg::OP_WRITE: begin
                if (slot_bad) begin
                    dec_status = hst_pkg::ST_BAD;
                end else begin
                    dec_go = 1'b1;
                end
            end
            default: dec_go = 1'b1;
        endcase
    end

    // status to the sequencer, valid in the decide step
    assign o_stat.is_range  = dec_range;
    assign o_stat.need_rd   = dec_go && (r_op == hst_pkg::OP_READ || r_op == hst_pkg::OP_WRITE
                              || (r_op == hst_pkg::OP_ALLOC && r_free != '0));
    assign o_stat.walk_last = (r_left == 11'd1);

    // memory addressing
    logic [3:0] wr_chg;
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            wr_chg[k] = r_mask[k] && (e_rd[k] != r_v[k]);
        end
    end

    logic [AW-1:0] top_idx;
    assign top_idx = AW'(r_free - CW'(1));

    logic [AW-1:0] alloc_h;
    assign alloc_h = (r_free != '0) ? s_rd : AW'(r_used);

    always_comb begin
        we_f    = '0;
        we_s    = 1'b0;
        e_addr  = AW'(r_slot);
        s_waddr = AW'(r_free);
        s_wd    = r_h;
        s_raddr = top_idx;
        for (int k = 0; k < 4; k++) begin
            e_wd[k] = '0;
        end
        if (i_cmd.walk) begin
            e_addr = r_h;
            we_f   = 4'hF;
            we_s   = (r_op == hst_pkg::OP_REL_RNG);
        end else if (i_cmd.exec && r_go) begin
            case (r_op)
                hst_pkg::OP_ALLOC: begin
                    e_addr = alloc_h;
                    we_f   = 4'hF;
                    for (int k = 0; k < 4; k++) begin
                        e_wd[k] = r_v[k];
                    end
                end
                hst_pkg::OP_RELEASE: begin
                    we_f = 4'hF;
                    we_s = 1'b1;
                    s_wd = AW'(r_slot);
                end
                hst_pkg::OP_WRITE: begin
                    we_f = wr_chg;
                    for (int k = 0; k < 4; k++) begin
                        e_wd[k] = r_v[k];
                    end
                end
                default: we_f = '0;
            endcase
        end
    end
    assign we_e = |we_f;

    // span merge helper inputs
    logic          mk;
    logic [AW-1:0] mk_f, mk_l;
    always_comb begin
        mk   = 1'b0;
        mk_f = AW'(r_slot);
        mk_l = AW'(r_slot);
        if (i_cmd.load) begin
            mk = 1'b0;
        end else if (i_cmd.walk && r_left == 11'd1) begin
            mk   = 1'b1;
            mk_f = r_base;
            mk_l = r_h;
        end else if (i_cmd.exec && r_go) begin
            case (r_op)
                hst_pkg::OP_ALLOC: begin
                    mk   = 1'b1;
                    mk_f = alloc_h;
                    mk_l = alloc_h;
                end
                hst_pkg::OP_RELEASE: mk = 1'b1;
                hst_pkg::OP_WRITE:   mk = we_e;
                default:             mk = 1'b0;
            endcase
        end
    end

    // flush span clamp
    logic [AW-1:0] fl_last;
    logic          fl_ok;
    assign fl_last = (CW'(r_high) > r_used - CW'(1)) ? AW'(r_used - CW'(1)) : r_high;
    assign fl_ok   = (r_low <= fl_last);

    // sequential state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '0;
            r_used <= '0;
            r_low  <= '1;
            r_high <= '0;
            r_mv   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (mk) begin
                if (!r_mv) begin
                    r_low  <= mk_f;
                    r_high <= mk_l;
                    r_mv   <= 1'b1;
                end else begin
                    if (mk_f < r_low)  r_low  <= mk_f;
                    if (mk_l > r_high) r_high <= mk_l;
                end
            end
            if (i_cmd.walk) begin
                if (r_op == hst_pkg::OP_REL_RNG) begin
                    r_free <= r_free + CW'(1);
                end else begin
                    r_used <= r_used + CW'(1);
                end
            end
            if (i_cmd.exec && r_go) begin
                case (r_op)
                    hst_pkg::OP_ALLOC: begin
                        if (r_free != '0) r_free <= r_free - CW'(1);
                        else              r_used <= r_used + CW'(1);
                    end
                    hst_pkg::OP_RELEASE: r_free <= r_free + CW'(1);
                    hst_pkg::OP_FLUSH: begin
                        if (r_used != '0 && r_mv) begin
                            r_low  <= '1;
                            r_high <= '0;
                            r_mv   <= 1'b0;
                        end
                    end
                    hst_pkg::OP_CLEAR: begin
                        r_used <= '0;
                        r_free <= '0;
                        r_low  <= '1;
                        r_high <= '0;
                        r_mv   <= 1'b0;
                    end
                    default: r_free <= r_free;
                endcase
            end
        end
    end

    // payload and results
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_operation;
            r_slot <= i_slot;
            r_cnt  <= i_span_count;
            r_mask <= i_field_mask;
            r_v[0] <= i_transform_in[ID_WIDTH-1:0];
            r_v[1] <= i_geometry_in[ID_WIDTH-1:0];
            r_v[2] <= i_material_in[ID_WIDTH-1:0];
            r_v[3] <= i_texture_in[ID_WIDTH-1:0];
            r_rslot <= '0;
            r_sv    <= 1'b0;
            r_sf    <= '0;
            r_sl    <= '0;
            for (int k = 0; k < 4; k++) begin
                r_rd[k] <= '0;
            end
        end
        // decide step: latch outcome and range setup
        if (!i_cmd.load && !i_cmd.walk && !i_cmd.exec && !i_cmd.finish && r_go_cap) begin
            r_status <= dec_status;
            r_go     <= dec_go;
            r_left   <= r_cnt;
            if (r_op == hst_pkg::OP_ALLOC_RNG) begin
                r_h    <= AW'(r_used);
                r_base <= AW'(r_used);
                // report the base only for a range that is granted
                if (dec_go) begin
                    r_rslot <= 10'(r_used);
                end
            end else begin
                r_h    <= AW'(r_slot);
                r_base <= AW'(r_slot);
            end
        end
        if (i_cmd.walk) begin
            r_h    <= r_h + AW'(1);
            r_left <= r_left - 11'd1;
        end
        if (i_cmd.exec && r_go) begin
            case (r_op)
                hst_pkg::OP_ALLOC: r_rslot <= 10'(alloc_h);
                hst_pkg::OP_READ: begin
                    for (int k = 0; k < 4; k++) begin
                        r_rd[k] <= 32'(e_rd[k]);
                    end
                end
                hst_pkg::OP_FLUSH: begin
                    if (r_used != '0 && r_mv && fl_ok) begin
                        r_sv <= 1'b1;
                        r_sf <= 10'(r_low);
                        r_sl <= 10'(fl_last);
                    end
                end
                default: r_sv <= r_sv;
            endcase
        end
    end

    // decide step marker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go_cap <= 1'b0;
        end else begin
            r_go_cap <= i_cmd.load;
        end
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_result_slot   = r_rslot;
    assign o_transform_out = r_rd[0];
    assign o_geometry_out  = r_rd[1];
    assign o_material_out  = r_rd[2];
    assign o_texture_out   = r_rd[3];
    assign o_span_valid    = r_sv;
    assign o_span_first    = r_sf;
    assign o_span_last     = r_sl;
endmodule
`default_nettype wire

// ===== rtl/handle_slot_table_with_dirty_range.sv =====
// -----------------------------------------------------------------------------
// handle_slot_table_with_dirty_range
// Slot table with LIFO handle reuse and one dirty span.
// -----------------------------------------------------------------------------
// Channel  | Signals                                  | Handshake
// request  | i_operation .. i_texture_in              | start && !busy
// result   | o_status .. o_span_last                  | o_done, one cycle
//
// Read, write and allocate from the free stack pass from accept to o_done
// through decide, a read of the entry and stack RAMs, execute and present;
// the other single requests skip the read.
// Granted range requests walk instead: the single write port of the entry
// RAMs zeroes one entry a cycle. busy drops in the cycle of the result strobe.
// Reset clears counters and span; RAM contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none
`include "handle_slot_table_with_dirty_range_macros.svh"
module handle_slot_table_with_dirty_range #(
    parameter int CAPACITY = 1024,
    parameter int ID_WIDTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [2:0]  i_operation,
    input  wire  [9:0]  i_slot,
    input  wire  [10:0] i_span_count,
    input  wire  [3:0]  i_field_mask,
    input  wire  [31:0] i_transform_in,
    input  wire  [31:0] i_geometry_in,
    input  wire  [31:0] i_material_in,
    input  wire  [31:0] i_texture_in,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [9:0]  o_result_slot,
    output logic [31:0] o_transform_out,
    output logic [31:0] o_geometry_out,
    output logic [31:0] o_material_out,
    output logic [31:0] o_texture_out,
    output logic        o_span_valid,
    output logic [9:0]  o_span_first,
    output logic [9:0]  o_span_last
);
    hst_pkg::t_cmd  cmd;
    hst_pkg::t_stat stat;

    hst_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_stat (stat),
        .o_cmd  (cmd),
        .o_busy (busy)
    );

    hst_dp #(.CAPACITY(CAPACITY), .ID_WIDTH(ID_WIDTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_operation    (i_operation),
        .i_slot         (i_slot),
        .i_span_count   (i_span_count),
        .i_field_mask   (i_field_mask),
        .i_transform_in (i_transform_in),
        .i_geometry_in  (i_geometry_in),
        .i_material_in  (i_material_in),
        .i_texture_in   (i_texture_in),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_result_slot  (o_result_slot),
        .o_transform_out(o_transform_out),
        .o_geometry_out (o_geometry_out),
        .o_material_out (o_material_out),
        .o_texture_out  (o_texture_out),
        .o_span_valid   (o_span_valid),
        .o_span_first   (o_span_first),
        .o_span_last    (o_span_last)
    );

    // a request starts only when idle, and the block is idle with each result
    `HST_ASSERT_IMP(a_done_frees, i_clk, i_rst_n, o_done, !busy, "busy during result")
    `HST_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_done,
        "accept did not start work")
    `HST_ASSERT_IMP(a_span_order, i_clk, i_rst_n, o_done && o_span_valid,
        o_span_first <= o_span_last, "flush span inverted")
endmodule
`default_nettype wire
